[src/nrzs_pkg.sv]
// nrzs_pkg: constants, types and register codes of the framed nrz sample serializer
// no dependencies; imported by every module and interface of the block
package nrzs_pkg;

	localparam int PAYLOAD_BYTES = 64;
	localparam int HEADER_BITS   = 32;
	localparam int FRAME_BITS    = HEADER_BITS + 8 * PAYLOAD_BYTES;
	localparam int POS_W         = $clog2(FRAME_BITS);
	localparam int ADDR_W        = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int PREAMBLE_BITS = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [7:0]  FILLER_BYTE      = 8'h55;
	localparam logic [14:0] AMPLITUDE_RESET  = 15'd15000;
	localparam logic [7:0]  SPS_RESET        = 8'd5;
	localparam logic [15:0] PREAMBLE_RESET   = 16'hAAAA;
	localparam logic [15:0] SYNC_RESET       = 16'hEB90;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BITS - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMPLITUDE = 3'd0,
		REG_SPS       = 3'd1,
		REG_PREAMBLE  = 3'd2,
		REG_SYNC      = 3'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             last;
	} frame_pos_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

endpackage

[src/nrzs_if.sv]
// nrzs_item_if and nrzs_result_if: valid/ready channels of the serializer
// depends on nrzs_pkg
interface nrzs_item_if;
	import nrzs_pkg::*;

	logic       valid;
	logic       ready;
	logic       op;
	logic [5:0] byte_index;
	logic [7:0] byte_value;

	modport source(output valid, op, byte_index, byte_value, input ready);
	modport sink(input valid, op, byte_index, byte_value, output ready);
endinterface

interface nrzs_result_if;
	import nrzs_pkg::*;

	logic              valid;
	logic              ready;
	logic signed [15:0] sample_value;
	logic [9:0]        bit_position;
	logic              frame_end;

	modport source(output valid, sample_value, bit_position, frame_end, input ready);
	modport sink(input valid, sample_value, bit_position, frame_end, output ready);
endinterface

[src/nrzs_payload_mem.sv]
// nrzs_payload_mem: payload byte memory with registered read and per-entry valid bits
// unwritten entries read as filler; depends on nrzs_pkg
module nrzs_payload_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  nrzs_pkg::mem_req_t req,
	output logic [7:0]        rd_data
);
	import nrzs_pkg::*;

	logic [7:0]               mem [PAYLOAD_BYTES];
	logic [PAYLOAD_BYTES-1:0] written_q;
	logic [7:0]               rdata_q;
	logic                     rvalid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rvalid_q  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				written_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_q <= written_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : FILLER_BYTE;

endmodule

[src/nrzs_frame_ctr.sv]
// nrzs_frame_ctr: frame bit and symbol sample counters, advanced once per tick beat
// depends on nrzs_pkg
module nrzs_frame_ctr (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	input  logic [7:0]           sps,
	output nrzs_pkg::frame_pos_t cur
);
	import nrzs_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       ssc_q;
	logic [7:0]       ssc_inc;
	logic             bit_done;
	logic             at_last;

	assign ssc_inc  = ssc_q + 8'd1;
	assign bit_done = (ssc_inc >= sps) || (ssc_inc == 8'd0);
	assign at_last  = (pos_q == LAST_POS);

	assign cur.pos  = pos_q;
	assign cur.last = bit_done && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ssc_q <= '0;
		end else if (tick) begin
			if (bit_done) begin
				ssc_q <= '0;
				pos_q <= at_last ? '0 : pos_q + POS_W'(1);
			end else begin
				ssc_q <= ssc_inc;
			end
		end
	end

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("frame bit counter beyond frame");

	a_wrap_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		tick && cur.last |=> pos_q == '0 && ssc_q == '0)
		else $error("counters did not wrap after last sample");

	a_hold_no_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!tick |=> $stable(pos_q) && $stable(ssc_q))
		else $error("counters moved without a tick");

endmodule

[src/framed_nrz_sample_serializer.sv]
// framed_nrz_sample_serializer: preamble, sync word and payload sent as +/-amplitude samples
// output: a tick beat yields its sample via stage 1 and stage 2; a load beat yields none
// throughput: one beat per cycle; a held result still takes loads and one more tick beat
// reset: registers to defaults, counters to frame start, payload reads as 0x55 filler
// depends on nrzs_pkg, nrzs_if, nrzs_payload_mem, nrzs_frame_ctr
module framed_nrz_sample_serializer (
	input  logic                             clk,
	input  logic                             arst_n,
	nrzs_item_if.sink                        item,
	nrzs_result_if.source                    result,
	input  logic                             cfg_we,
	input  logic [nrzs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nrzs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import nrzs_pkg::*;

	logic [14:0] amplitude_q;
	logic [7:0]  sps_q;
	logic [15:0] preamble_q;
	logic [15:0] sync_q;

	logic       accept;
	logic       tick;
	logic       load;
	logic       adv;
	frame_pos_t cur;
	mem_req_t   mreq;
	logic [7:0] rd_data;
	logic [8:0] idx_ext;
	logic [POS_W-1:0] rel;

	logic             s1_valid_q;
	logic [POS_W-1:0] pos_s1;
	logic             last_s1;

	logic              s2_valid_q;
	logic [15:0]       sample_s2;
	logic [9:0]        bitpos_s2;
	logic              last_s2;

	logic              bit_val;
	logic [15:0]       amp16;
	logic [15:0]       sample_c;
	logic [POS_W+9:0]  pos_wide;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= AMPLITUDE_RESET;
			sps_q       <= SPS_RESET;
			preamble_q  <= PREAMBLE_RESET;
			sync_q      <= SYNC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_AMPLITUDE: amplitude_q <= cfg_wdata[14:0];
				REG_SPS:       sps_q       <= cfg_wdata[7:0];
				REG_PREAMBLE:  preamble_q  <= cfg_wdata;
				REG_SYNC:      sync_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake
	assign adv        = !s2_valid_q || result.ready;
	assign item.ready = !s1_valid_q || adv;
	assign accept     = item.valid && item.ready;
	assign tick       = accept && (op_t'(item.op) == OP_TICK);
	assign load       = accept && (op_t'(item.op) == OP_LOAD);

	nrzs_frame_ctr u_ctr (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.sps    (sps_q),
		.cur    (cur)
	);

	assign idx_ext = {3'b000, item.byte_index};
	assign rel     = cur.pos - POS_W'(HEADER_BITS);

	assign mreq.wr_en   = load && (int'(item.byte_index) < PAYLOAD_BYTES);
	assign mreq.wr_addr = idx_ext[ADDR_W-1:0];
	assign mreq.wr_data = item.byte_value;
	assign mreq.rd_en   = tick;
	assign mreq.rd_addr = rel[ADDR_W+2:3];

	nrzs_payload_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.rd_data (rd_data)
	);

	// stage 1: position of the tick, payload byte arrives from the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item.ready) begin
			s1_valid_q <= tick;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			pos_s1  <= cur.pos;
			last_s1 <= cur.last;
		end
	end

	// bit select and antipodal mapping
	always_comb begin
		if (pos_s1 < POS_W'(PREAMBLE_BITS)) begin
			bit_val = preamble_q[~pos_s1[3:0]];
		end else if (pos_s1 < POS_W'(HEADER_BITS)) begin
			bit_val = sync_q[~pos_s1[3:0]];
		end else begin
			bit_val = rd_data[~pos_s1[2:0]];
		end
	end

	assign amp16    = {1'b0, amplitude_q};
	assign sample_c = bit_val ? amp16 : (~amp16 + 16'd1);
	assign pos_wide = {10'd0, pos_s1};

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (adv) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			sample_s2 <= sample_c;
			bitpos_s2 <= pos_wide[9:0];
			last_s2   <= last_s1;
		end
	end

	assign result.valid        = s2_valid_q;
	assign result.sample_value = $signed(sample_s2);
	assign result.bit_position = bitpos_s2;
	assign result.frame_end    = last_s2;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> s1_valid_q && s2_valid_q)
		else $error("input stalled with room in the pipeline");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !adv |=> s1_valid_q && $stable(pos_s1) && $stable(last_s1))
		else $error("stage 1 lost its beat while stalled");

	a_end_at_last_bit: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && last_s1 |-> pos_s1 == LAST_POS)
		else $error("frame end away from last frame bit");

endmodule
